@@ hdl/fvbt_pkg.sv @@
// shared types and constants of the fec video block tracker
package fvbt_pkg;

    localparam int C_MAX_SHARDS = 1024;
    localparam int EPOCH_W      = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

    // reciprocal of 100 for x < 2**18: floor(x/100) = (x * RECIP_100) >> RECIP_SH
    localparam int RECIP_SH = 25;
    localparam logic [18:0] RECIP_100 = 19'd335545;
    localparam logic [17:0] PARITY_ROUND = 18'd99;

    localparam logic [15:0] DSZ_RESET = 16'd1024;
    localparam logic [31:0] TMO_RESET = 32'd300000000;
    localparam logic [15:0] DSZ_MIN   = 16'd40;
    localparam logic [7:0]  HDR_MASK  = 8'h90;
    localparam logic [12:0] FEC_TOTAL_MAX = 13'd255;

    localparam logic [1:0] REG_DSZ = 2'd0;
    localparam logic [1:0] REG_TMO = 2'd1;

    typedef enum logic [2:0] {
        ST_ACCEPT = 3'd0,
        ST_MALFORMED = 3'd1,
        ST_LATE = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_ORDER = 3'd4
    } t_status;

    typedef struct packed {
        logic        malformed;
        logic [31:0] frame;
        logic [1:0]  cur;
        logic [1:0]  last;
        logic [9:0]  idx;
        logic [9:0]  dc;
        logic [7:0]  pct;
        logic [7:0]  parity;
        logic [15:0] base;
        logic [63:0] t;
    } t_cmd;

    typedef struct packed {
        t_status     status;
        logic        loss_v;
        logic [31:0] loss_f;
        logic        pred;
        logic        blk_done;
        logic        frm_done;
        logic [9:0]  recover;
        logic        reord;
    } t_res;

endpackage

@@ hdl/fec_video_block_tracker.sv @@
// top level of the fec video block tracker
//
//  channel   direction  handshake            content
//  input     in         push / full          one packet header per item
//  result    out        pop / empty          one status record per item
//  config    in         i_cfg_valid / ready  register index and data
//
// front end takes one item a cycle, unless full, into a two-stage decode pipeline
// back end handles each item as a tag memory read, then execute and write
// the back end takes no new item until the last one is written
// after reset every tag memory entry is swept to zero before the first item
// the same sweep runs again once every 255 block openings
// either side may stall; two-entry queues decouple decode, execute and result
module fec_video_block_tracker #(
    parameter int MAX_SHARDS = fvbt_pkg::C_MAX_SHARDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_packet_length,
    input  logic [7:0]  i_first_byte,
    input  logic [15:0] i_sequence_number,
    input  logic [31:0] i_frame_number,
    input  logic [31:0] i_fec_word,
    input  logic [7:0]  i_block_byte,
    input  logic [63:0] i_arrival_time_us,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic        o_final_loss_valid,
    output logic [31:0] o_final_loss_frame,
    output logic        o_predicted_loss,
    output logic        o_block_complete,
    output logic        o_frame_complete,
    output logic [9:0]  o_recover_count,
    output logic        o_reordered,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import fvbt_pkg::*;

    // configuration registers
    logic [15:0] r_dsz;
    logic [31:0] r_tmo;

    t_cmd f_cmd, q_cmd;
    logic f_valid, q_full, q_empty, q_pop;
    t_res b_res, o_res;
    logic b_push, r_full;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dsz <= DSZ_RESET;
            r_tmo <= TMO_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DSZ: r_dsz <= i_cfg_data[15:0];
                REG_TMO: r_tmo <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // decode pipeline
    fvbt_front #(.MAX_SHARDS(MAX_SHARDS)) u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full),
        .i_packet_length, .i_first_byte, .i_sequence_number, .i_frame_number,
        .i_fec_word, .i_block_byte, .i_arrival_time_us,
        .i_dsz(r_dsz), .o_cmd_valid(f_valid), .o_cmd(f_cmd), .i_cmd_full(q_full)
    );

    // command queue between decode and execute
    fvbt_fifo #(.W($bits(t_cmd))) u_cmdq (
        .i_clk, .i_rst_n, .i_push(f_valid), .i_data(f_cmd), .o_full(q_full),
        .i_pop(q_pop), .o_data(q_cmd), .o_empty(q_empty)
    );

    // block tracking and shard bitmap
    fvbt_back #(.MAX_SHARDS(MAX_SHARDS)) u_back (
        .i_clk, .i_rst_n, .i_cmd_empty(q_empty), .i_cmd(q_cmd), .o_cmd_pop(q_pop),
        .i_tmo(r_tmo), .o_res_push(b_push), .o_res(b_res), .i_res_full(r_full)
    );

    // result queue, its head drives the ports
    fvbt_fifo #(.W($bits(t_res))) u_resq (
        .i_clk, .i_rst_n, .i_push(b_push), .i_data(b_res), .o_full(r_full),
        .i_pop(pop), .o_data(o_res), .o_empty(empty)
    );

    assign o_status           = o_res.status;
    assign o_final_loss_valid = o_res.loss_v;
    assign o_final_loss_frame = o_res.loss_f;
    assign o_predicted_loss   = o_res.pred;
    assign o_block_complete   = o_res.blk_done;
    assign o_frame_complete   = o_res.frm_done;
    assign o_recover_count    = o_res.recover;
    assign o_reordered        = o_res.reord;
endmodule

@@ hdl/fvbt_fifo.sv @@
// two-entry queue used between front and back and on the result side
module fvbt_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         do_push;
    logic         do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= !r_wp;
            if (do_pop) r_rp <= !r_rp;
            if (do_push && !do_pop) r_cnt <= r_cnt + 2'd1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 2'd1;
        end
        if (do_push) r_mem[r_wp] <= i_data;
    end
endmodule

@@ hdl/fvbt_front.sv @@
// header decode: parity count, field checks, command build
module fvbt_front #(
    parameter int MAX_SHARDS = fvbt_pkg::C_MAX_SHARDS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic [15:0]         i_packet_length,
    input  logic [7:0]          i_first_byte,
    input  logic [15:0]         i_sequence_number,
    input  logic [31:0]         i_frame_number,
    input  logic [31:0]         i_fec_word,
    input  logic [7:0]          i_block_byte,
    input  logic [63:0]         i_arrival_time_us,
    input  logic [15:0]         i_dsz,
    output logic                o_cmd_valid,
    output fvbt_pkg::t_cmd      o_cmd,
    input  logic                i_cmd_full
);
    import fvbt_pkg::*;

    logic        r_v1, r_v2;
    logic [15:0] r_plen1, r_plen2;
    logic [7:0]  r_b01, r_b02;
    logic [15:0] r_seq1, r_seq2;
    logic [31:0] r_frm1, r_frm2;
    logic [31:0] r_fec1, r_fec2;
    logic [7:0]  r_bb1, r_bb2;
    logic [63:0] r_t1, r_t2;
    logic [17:0] r_prod;
    logic [11:0] r_par;
    logic        ld1, ld2;
    logic [36:0] quot;
    logic [9:0]  dc, idx;
    logic [7:0]  pct;
    logic [1:0]  cur, last;
    logic [12:0] total;

    assign ld2 = !r_v2 || !i_cmd_full;
    assign ld1 = !r_v1 || ld2;
    assign o_full = !ld1;
    // ceil(dc*pct/100) by reciprocal multiply
    assign quot = (r_prod + PARITY_ROUND) * RECIP_100;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (ld1) r_v1 <= i_push;
            if (ld2) r_v2 <= r_v1;
        end
        if (ld1 && i_push) begin
            r_plen1 <= i_packet_length;
            r_b01   <= i_first_byte;
            r_seq1  <= i_sequence_number;
            r_frm1  <= i_frame_number;
            r_fec1  <= i_fec_word;
            r_bb1   <= i_block_byte;
            r_t1    <= i_arrival_time_us;
            r_prod  <= i_fec_word[31:22] * i_fec_word[11:4];
        end
        if (ld2 && r_v1) begin
            r_plen2 <= r_plen1;
            r_b02   <= r_b01;
            r_seq2  <= r_seq1;
            r_frm2  <= r_frm1;
            r_fec2  <= r_fec1;
            r_bb2   <= r_bb1;
            r_t2    <= r_t1;
            r_par   <= quot[RECIP_SH +: 12];
        end
    end

    always_comb begin
        dc    = r_fec2[31:22];
        idx   = r_fec2[21:12];
        pct   = r_fec2[11:4];
        cur   = r_bb2[5:4];
        last  = r_bb2[7:6];
        total = {3'b0, dc} + {1'b0, r_par};
        o_cmd_valid     = r_v2;
        o_cmd.malformed = (i_dsz <= DSZ_MIN) || (r_plen2 != i_dsz)
                       || ((r_b02 & HDR_MASK) != HDR_MASK) || (dc == 10'd0)
                       || ({3'b0, idx} >= total) || (cur > last)
                       || ((r_par != 12'd0) && (total > FEC_TOTAL_MAX))
                       || (total > 13'(MAX_SHARDS));
        o_cmd.frame  = r_frm2;
        o_cmd.cur    = cur;
        o_cmd.last   = last;
        o_cmd.idx    = idx;
        o_cmd.dc     = dc;
        o_cmd.pct    = pct;
        o_cmd.parity = r_par[7:0];
        o_cmd.base   = r_seq2 - {6'b0, idx};
        o_cmd.t      = r_t2;
    end
endmodule

@@ hdl/fvbt_back.sv @@
// block and frame tracking with the shard bitmap kept as epoch tags
module fvbt_back #(
    parameter int MAX_SHARDS = fvbt_pkg::C_MAX_SHARDS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_empty,
    input  fvbt_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    input  logic [31:0]    i_tmo,
    output logic           o_res_push,
    output fvbt_pkg::t_res o_res,
    input  logic           i_res_full
);
    import fvbt_pkg::*;

    localparam int IW = $clog2(MAX_SHARDS);

    typedef enum logic [1:0] {S_SWEEP, S_READ, S_EXEC} t_state;

    t_state             r_state;
    logic [IW-1:0]      r_swp;
    logic               r_after;
    logic [EPOCH_W-1:0] r_tags [MAX_SHARDS];
    logic [EPOCH_W-1:0] r_rd;
    logic [EPOCH_W-1:0] r_epoch, n_epoch;
    t_cmd               r_item;
    logic [31:0] r_exp_frame, n_exp_frame;
    logic [1:0]  r_exp_blk, n_exp_blk;
    logic        r_loss_rep, n_loss_rep;
    logic        r_reo_seen, n_reo_seen;
    logic [63:0] r_last_t, n_last_t;
    logic        r_open, n_open;
    logic [15:0] r_base, n_base;
    logic [9:0]  r_dc, n_dc;
    logic [7:0]  r_par, n_par;
    logic [7:0]  r_pct, n_pct;
    logic [1:0]  r_lastidx, n_lastidx;
    logic [9:0]  r_high, n_high;
    logic [9:0]  r_gaps, n_gaps;
    logic [10:0] r_rcv, n_rcv;
    logic [10:0] r_drcv, n_drcv;
    logic        need_sweep, shard_wr, opening, fresh, ok;
    logic [31:0] fdiff;
    logic [1:0]  want;
    logic        commit;
    t_res        res;

    always_comb begin
        n_epoch = r_epoch;       n_exp_frame = r_exp_frame; n_exp_blk = r_exp_blk;
        n_loss_rep = r_loss_rep; n_reo_seen = r_reo_seen;   n_last_t = r_last_t;
        n_open = r_open;         n_base = r_base;           n_dc = r_dc;
        n_par = r_par;           n_pct = r_pct;             n_lastidx = r_lastidx;
        n_high = r_high;         n_gaps = r_gaps;           n_rcv = r_rcv;
        n_drcv = r_drcv;
        res = '0;
        res.status = ST_ACCEPT;
        need_sweep = 1'b0;
        shard_wr = 1'b0;
        fresh = 1'b0;
        ok = 1'b0;
        fdiff = r_item.frame - r_exp_frame;
        opening = !r_open || (r_item.frame != r_exp_frame) || (r_item.cur != r_exp_blk);
        want = (r_item.frame == r_exp_frame) ? r_exp_blk : 2'd0;
        if (r_item.malformed) begin
            res.status = ST_MALFORMED;
        end else if (fdiff[31] || ((r_item.frame == r_exp_frame)
                                   && (r_item.cur < r_exp_blk))) begin
            res.status = ST_LATE;
        end else if (opening) begin
            if (r_item.cur != want) begin
                if (!r_loss_rep) begin
                    res.loss_v = 1'b1;
                    res.loss_f = r_exp_frame;
                    n_loss_rep = 1'b1;
                end
                n_exp_frame = r_item.frame + 32'd1;
                n_exp_blk = 2'd0;
                n_open = 1'b0;
                res.status = ST_ORDER;
            end else if (r_epoch == EPOCH_MAX) begin
                need_sweep = 1'b1;
            end else begin
                if ((r_item.frame != r_exp_frame)
                    && ((r_exp_frame + 32'd1 != r_item.frame) || !r_loss_rep)) begin
                    res.loss_v = 1'b1;
                    res.loss_f = r_item.frame - 32'd1;
                end
                n_exp_frame = r_item.frame;
                n_exp_blk = r_item.cur;
                n_loss_rep = 1'b0;
                n_open = 1'b1;
                n_base = r_item.base;
                n_dc = r_item.dc;
                n_par = r_item.parity;
                n_pct = r_item.pct;
                n_lastidx = r_item.last;
                n_epoch = r_epoch + 1'b1;
                n_high = '0;
                n_gaps = '0;
                n_rcv = '0;
                n_drcv = '0;
                fresh = 1'b1;
                ok = 1'b1;
            end
        end else if ((r_item.base != r_base) || (r_item.dc != r_dc)
                     || (r_item.parity != r_par) || (r_item.pct != r_pct)
                     || (r_item.last != r_lastidx)) begin
            res.status = ST_MALFORMED;
        end else begin
            ok = 1'b1;
        end

        if (ok) begin
            if (!fresh && (r_rd == r_epoch)) begin
                res.status = ST_DUPLICATE;
            end else begin
                if ((n_rcv != 11'd0) && (r_item.idx < n_high)) begin
                    res.reord = 1'b1;
                    n_reo_seen = 1'b1;
                    n_last_t = r_item.t;
                end else if (n_reo_seen && (r_item.t > n_last_t)
                             && ((r_item.t - n_last_t) > {32'b0, i_tmo})) begin
                    n_reo_seen = 1'b0;
                end
                if (n_rcv == 11'd0) begin
                    n_high = r_item.idx;
                    n_gaps = r_item.idx;
                end else if (r_item.idx > n_high) begin
                    n_gaps = n_gaps + r_item.idx - n_high - 10'd1;
                    n_high = r_item.idx;
                end else begin
                    n_gaps = n_gaps - 10'd1;
                end
                shard_wr = 1'b1;
                n_rcv = n_rcv + 11'd1;
                if (r_item.idx < r_item.dc) n_drcv = n_drcv + 11'd1;
                if (n_rcv < {1'b0, r_item.dc}) begin
                    if (!n_loss_rep && !n_reo_seen && (n_gaps > {2'b0, r_item.parity})) begin
                        res.pred = 1'b1;
                        n_loss_rep = 1'b1;
                    end
                end else begin
                    if (n_loss_rep && !n_reo_seen) begin
                        n_reo_seen = 1'b1;
                        n_last_t = r_item.t;
                    end
                    if (n_drcv < {1'b0, r_item.dc})
                        res.recover = r_item.dc - n_drcv[9:0];
                    res.blk_done = 1'b1;
                    if (r_item.cur == r_item.last) begin
                        res.frm_done = 1'b1;
                        n_exp_frame = n_exp_frame + 32'd1;
                        n_exp_blk = 2'd0;
                    end else begin
                        n_exp_blk = n_exp_blk + 2'd1;
                    end
                    n_open = 1'b0;
                end
            end
        end
    end

    assign commit     = (r_state == S_EXEC) && !need_sweep && !i_res_full;
    assign o_res_push = commit;
    assign o_res      = res;
    assign o_cmd_pop  = (r_state == S_READ) && !i_cmd_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_swp <= '0;
            r_after <= 1'b0;
            r_epoch <= '0;
            r_exp_frame <= 32'd1;
            r_exp_blk <= 2'd0;
            r_loss_rep <= 1'b0;
            r_reo_seen <= 1'b0;
            r_last_t <= '0;
            r_open <= 1'b0;
            r_base <= '0;
            r_dc <= '0;
            r_par <= '0;
            r_pct <= '0;
            r_lastidx <= '0;
            r_high <= '0;
            r_gaps <= '0;
            r_rcv <= '0;
            r_drcv <= '0;
        end else begin
            case (r_state)
                S_SWEEP: begin
                    r_swp <= r_swp + 1'b1;
                    if (r_swp == IW'(MAX_SHARDS - 1)) begin
                        r_epoch <= '0;
                        r_state <= r_after ? S_EXEC : S_READ;
                    end
                end
                S_READ: begin
                    if (!i_cmd_empty) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (need_sweep) begin
                        r_swp <= '0;
                        r_after <= 1'b1;
                        r_state <= S_SWEEP;
                    end else if (!i_res_full) begin
                        r_after <= 1'b0;
                        r_state <= S_READ;
                        r_epoch <= n_epoch;
                        r_exp_frame <= n_exp_frame;
                        r_exp_blk <= n_exp_blk;
                        r_loss_rep <= n_loss_rep;
                        r_reo_seen <= n_reo_seen;
                        r_last_t <= n_last_t;
                        r_open <= n_open;
                        r_base <= n_base;
                        r_dc <= n_dc;
                        r_par <= n_par;
                        r_pct <= n_pct;
                        r_lastidx <= n_lastidx;
                        r_high <= n_high;
                        r_gaps <= n_gaps;
                        r_rcv <= n_rcv;
                        r_drcv <= n_drcv;
                    end
                end
                default: r_state <= S_SWEEP;
            endcase
        end
    end

    // tag memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_state == S_SWEEP)
            r_tags[r_swp] <= '0;
        else if (commit && shard_wr)
            r_tags[r_item.idx[IW-1:0]] <= n_epoch;
        if (o_cmd_pop) begin
            r_rd <= r_tags[i_cmd.idx[IW-1:0]];
            r_item <= i_cmd;
        end
    end
endmodule

@@ hdl/fvbt_checker.sv @@
// port checker for the fec video block tracker and its bind
module fvbt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  o_status,
    input logic        o_final_loss_valid,
    input logic [31:0] o_final_loss_frame,
    input logic        o_block_complete,
    input logic        o_frame_complete,
    input logic [9:0]  o_recover_count,
    input logic        o_reordered
);
    import fvbt_pkg::*;

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_status <= 3'(ST_ORDER)))
        else $error("status code out of range");

    a_recover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_recover_count != 10'd0) |-> (o_block_complete
                                                 && o_status == 3'(ST_ACCEPT)))
        else $error("recovery without completed block");

    a_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_frame_complete) |-> o_block_complete)
        else $error("frame complete without block complete");

    a_reord: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_reordered || o_block_complete)) |-> (o_status == 3'(ST_ACCEPT)))
        else $error("accept-only flag on rejected item");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_status)
                              && $stable(o_final_loss_valid)
                              && $stable(o_final_loss_frame)))
        else $error("waiting result changed");
endmodule

bind fec_video_block_tracker fvbt_checker u_fvbt_checker (
    .i_clk, .i_rst_n, .empty, .pop, .o_status, .o_final_loss_valid,
    .o_final_loss_frame, .o_block_complete, .o_frame_complete,
    .o_recover_count, .o_reordered
);
